/* hw/rtl/sfd_pkg.sv */
// Shared constants and control types for the SBUS frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

    // Frame layout
    localparam logic [7:0] START_BYTE  = 8'h0F;
    localparam int         BYTE_W      = 8;
    localparam int         POS_W       = 5;
    localparam logic [4:0] END_POS     = 5'd24;
    localparam int         STORE_BYTES = 23;                  // bytes 1..23, start byte not kept
    localparam int         STORE_W     = STORE_BYTES * BYTE_W;

    // Result layout
    localparam int          IDX_W      = 5;
    localparam int          CH_W       = 11;
    localparam int          FS_W       = 2;
    localparam int          LOST_W     = 8;
    localparam int          ERR_W      = 16;
    localparam logic [4:0]  DIG0_IDX   = 5'd16;
    localparam logic [4:0]  DIG1_IDX   = 5'd17;
    localparam logic [10:0] CH_FULL    = 11'h7FF;

    // Controller to datapath commands
    typedef struct packed {
        logic             shift_in;   // store a frame byte
        logic             load_bad;   // rejected frame result
        logic             load_good;  // good frame, first result
        logic             load_next;  // next result of a good frame
        logic [IDX_W-1:0] index;      // channel to present
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_start;
        logic is_zero;
    } status_t;

endpackage

/* hw/rtl/sfd_rx_if.sv */
// Byte request channel: valid/ready with one received byte.
`timescale 1ns / 1ps

interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/sfd_res_if.sv */
// Result request channel: valid/ready with one decoded channel.
`timescale 1ns / 1ps

interface sfd_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  channel_index;
    logic [10:0] channel_value;
    logic [1:0]  failsafe_bits;
    logic [7:0]  lost_count;
    logic [15:0] error_count;
    logic        frame_bad;
    logic        last;

    modport source (output valid, output channel_index, output channel_value,
                    output failsafe_bits, output lost_count, output error_count,
                    output frame_bad, output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input failsafe_bits, input lost_count, input error_count,
                    input frame_bad, input last, output ready);
endinterface

/* hw/rtl/sfd_ctrl.sv */
// Frame sequencer: byte position, result sequencing and handshakes.
`timescale 1ns / 1ps

module sfd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rx_valid,
    output logic                   rx_ready,
    output logic                   res_valid,
    input  logic                   res_ready,
    input  sfd_pkg::status_t       status,
    output sfd_pkg::cmd_t          cmd
);

    localparam logic [0:0] S_RX   = 1'b0;
    localparam logic [0:0] S_EMIT = 1'b1;

    logic [0:0]                  state_reg, state_next;
    logic [sfd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [sfd_pkg::IDX_W-1:0]   ch_reg, ch_next;
    logic                        valid_reg, valid_next;
    logic                        rx_acc;
    logic                        res_take;

    // Only the end byte needs the result slot free or being emptied
    assign rx_ready  = (state_reg == S_RX) &&
                       ((pos_reg != sfd_pkg::END_POS) || !valid_reg || res_ready);
    assign rx_acc    = rx_valid && rx_ready;
    assign res_take  = valid_reg && res_ready;
    assign res_valid = valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ch_next    = ch_reg;
        valid_next = valid_reg && !res_take;
        cmd        = '0;
        unique case (state_reg)
            S_RX:
            begin
                if (rx_acc)
                begin
                    priority if (pos_reg == '0)
                    begin
                        // hunting for the start byte
                        if (status.is_start)
                            pos_next = pos_reg + 1'b1;
                    end
                    else if (pos_reg == sfd_pkg::END_POS)
                    begin
                        pos_next   = '0;
                        valid_next = 1'b1;
                        if (status.is_zero)
                        begin
                            cmd.load_good = 1'b1;
                            cmd.index     = '0;
                            ch_next       = sfd_pkg::IDX_W'(1);
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            cmd.load_bad = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.shift_in = 1'b1;
                        pos_next     = pos_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (res_take)
                begin
                    cmd.load_next = 1'b1;
                    cmd.index     = ch_reg;
                    valid_next    = 1'b1;
                    ch_next       = ch_reg + 1'b1;
                    if (ch_reg == sfd_pkg::DIG1_IDX)
                        state_next = S_RX;
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RX;
            pos_reg   <= '0;
            ch_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ch_reg    <= ch_next;
            valid_reg <= valid_next;
        end
    end

endmodule

/* hw/rtl/sfd_datapath.sv */
// Frame store shift line, channel unpacking, counters and result register.
`timescale 1ns / 1ps

module sfd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
    input  sfd_pkg::cmd_t                 cmd,
    output sfd_pkg::status_t              status,
    output logic [sfd_pkg::IDX_W-1:0]     channel_index,
    output logic [sfd_pkg::CH_W-1:0]      channel_value,
    output logic [sfd_pkg::FS_W-1:0]      failsafe_bits,
    output logic [sfd_pkg::LOST_W-1:0]    lost_count,
    output logic [sfd_pkg::ERR_W-1:0]     error_count,
    output logic                          frame_bad,
    output logic                          last
);

    logic [sfd_pkg::STORE_W-1:0]   store_reg, store_next;
    logic [sfd_pkg::BYTE_W-1:0]    flags_reg, flags_next;
    logic [sfd_pkg::BYTE_W-1:0]    store_flags;
    logic [sfd_pkg::LOST_W-1:0]    lost_reg, lost_next;
    logic [sfd_pkg::ERR_W-1:0]     err_reg, err_next;
    logic [sfd_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [sfd_pkg::CH_W-1:0]      value_reg, value_next;
    logic [sfd_pkg::FS_W-1:0]      fs_reg, fs_next;
    logic                          bad_reg, bad_next;
    logic                          last_reg, last_next;
    logic                          load_ch;

    assign status.is_start = (rx_byte == sfd_pkg::START_BYTE);
    assign status.is_zero  = (rx_byte == '0);

    // Flag byte sits at the top of the line once the frame is in
    assign store_flags = store_reg[sfd_pkg::STORE_W-1 -: sfd_pkg::BYTE_W];
    assign load_ch     = cmd.load_good || cmd.load_next;

    always_comb
    begin
        store_next = store_reg;
        flags_next = flags_reg;
        lost_next  = lost_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        fs_next    = fs_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;

        // Frame bytes shift in from the top; byte 1 ends at the bottom
        if (cmd.shift_in)
            store_next = {rx_byte, store_reg[sfd_pkg::STORE_W-1:sfd_pkg::BYTE_W]};

        // Rejected frame
        if (cmd.load_bad)
        begin
            err_next   = err_reg + 1'b1;
            idx_next   = '0;
            value_next = '0;
            fs_next    = '0;
            bad_next   = 1'b1;
            last_next  = 1'b1;
        end

        // Good frame: latch flags, count a lost frame
        if (cmd.load_good)
        begin
            flags_next = store_flags;
            fs_next    = store_flags[3:2];
            if (store_flags[2])
                lost_next = lost_reg + 1'b1;
        end

        // Present one channel; analog ones come off the bottom of the line
        if (load_ch)
        begin
            idx_next  = cmd.index;
            bad_next  = 1'b0;
            last_next = (cmd.index == sfd_pkg::DIG1_IDX);
            priority if (cmd.index == sfd_pkg::DIG0_IDX)
            begin
                value_next = flags_reg[0] ? sfd_pkg::CH_FULL : '0;
            end
            else if (cmd.index == sfd_pkg::DIG1_IDX)
            begin
                value_next = flags_reg[1] ? sfd_pkg::CH_FULL : '0;
            end
            else
            begin
                value_next = store_reg[sfd_pkg::CH_W-1:0];
                store_next = {{sfd_pkg::CH_W{1'b0}},
                              store_reg[sfd_pkg::STORE_W-1:sfd_pkg::CH_W]};
            end
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_reg <= '0;
            err_reg  <= '0;
        end
        else
        begin
            lost_reg <= lost_next;
            err_reg  <= err_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        flags_reg <= flags_next;
        idx_reg   <= idx_next;
        value_reg <= value_next;
        fs_reg    <= fs_next;
        bad_reg   <= bad_next;
        last_reg  <= last_next;
    end

    assign channel_index = idx_reg;
    assign channel_value = value_reg;
    assign failsafe_bits = fs_reg;
    assign lost_count    = lost_reg;
    assign error_count   = err_reg;
    assign frame_bad     = bad_reg;
    assign last          = last_reg;

endmodule

/* hw/rtl/sbus_frame_decoder_unit.sv */
// SBUS frame decoder top level: byte channel in, channel results out.
//
// rx carries received serial bytes, one per request. Bytes are dropped
// until the start byte 0x0F; the next 23 bytes are stored and the 25th is
// the end byte. A zero end byte yields 18 requests on chan: analog channels
// 0..15, then digital channels 16 and 17 (0 or 2047), the last one marked
// with last. A nonzero end byte yields one request with frame_bad and last.
// The first result is valid the cycle after the end byte is taken.
// Throughput: one byte per cycle while a frame is received; after a good
// end byte the 18 results leave one per cycle while chan is ready, and rx
// stays not ready until the last result is loaded. The limit is the
// single result register that the channel sequencer refills once per
// taken result.
// When chan stalls, the pending result holds and rx stays ready only until
// an end byte needs the result register. Reset clears the byte position,
// both counters and the result valid; the frame store is not cleared.
`timescale 1ns / 1ps

module sbus_frame_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    sfd_rx_if.sink        rx,
    sfd_res_if.source     chan
);

    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t status;

    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_ready  (rx.ready),
        .res_valid (chan.valid),
        .res_ready (chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx.rx_byte),
        .cmd           (cmd),
        .status        (status),
        .channel_index (chan.channel_index),
        .channel_value (chan.channel_value),
        .failsafe_bits (chan.failsafe_bits),
        .lost_count    (chan.lost_count),
        .error_count   (chan.error_count),
        .frame_bad     (chan.frame_bad),
        .last          (chan.last)
    );

endmodule

/* hw/rtl/sfd_checker.sv */
// Port-level checks for the SBUS frame decoder, bound to the top level.
`timescale 1ns / 1ps

module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_ready,
    input logic        chan_valid,
    input logic        chan_ready,
    input logic [4:0]  channel_index,
    input logic [10:0] channel_value,
    input logic        frame_bad,
    input logic        last
);

    // A stalled result keeps its index and value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chan_valid && !chan_ready |=>
            chan_valid && $stable(channel_index) && $stable(channel_value))
        else $error("stalled result changed");

    // A rejected frame gives one zeroed, final result
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        chan_valid && frame_bad |->
            last && channel_index == 5'd0 && channel_value == 11'd0)
        else $error("bad frame result malformed");

    // Byte input is held off while a frame's results are still going out
    a_burst_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        chan_valid && !last |-> !rx_ready)
        else $error("rx ready during result burst");

    // Results of a good frame follow back to back in index order
    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        chan_valid && chan_ready && !last |=>
            chan_valid && channel_index == 5'($past(channel_index) + 5'd1))
        else $error("result index sequence broken");

    // Digital channels read all zeros or all ones
    a_digital: assert property (@(posedge clk) disable iff (!rst_n)
        chan_valid && channel_index >= 5'd16 |->
            channel_value == 11'd0 || channel_value == 11'h7FF)
        else $error("digital channel value invalid");

endmodule

bind sbus_frame_decoder_unit sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .chan_valid    (chan.valid),
    .chan_ready    (chan.ready),
    .channel_index (chan.channel_index),
    .channel_value (chan.channel_value),
    .frame_bad     (chan.frame_bad),
    .last          (chan.last)
);
